// ===== rtl/core/drt_pkg.sv =====
package drt_pkg;

   localparam int VEL_W   = 24;
   localparam int TEMP_W  = 32;
   localparam int COEF_W  = 24;
   localparam int SQ_W    = 48;
   localparam int ROOT_W  = 24;
   localparam int REM_W   = 26;
   localparam int DEN_W   = 25;
   localparam int QUO_W   = 20;
   localparam int RATE_W  = 28;
   localparam int DIFF_W  = 33;
   localparam int FMAG_W  = 45;
   localparam int RES_W   = 48;

   localparam logic [QUO_W-1:0]  RATE_LIMIT     = 20'd655360;
   localparam logic [COEF_W-1:0] DRAG_RESET     = 24'd0;
   localparam logic [COEF_W-1:0] INV_H_RESET    = 24'd65536;
   localparam logic [TEMP_W-1:0] SOIL_RESET     = 32'd19660800;

   typedef enum logic [1:0] {
      CSR_DRAG_COEFF      = 2'd0,
      CSR_INV_CELL_HEIGHT = 2'd1,
      CSR_SOIL_TEMP       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     solid;
      logic signed [DIFF_W-1:0] diff;
      logic signed [TEMP_W-1:0] src;
   } pay_type;

   function automatic logic [VEL_W-1:0] vel_mag(input logic [VEL_W-1:0] v);
      vel_mag = v[VEL_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== rtl/core/drag_temperature_relaxation.sv =====
// Throughput: one cell per cycle while the pipeline does not hold; the 24-stage square root and the
// 20-stage restoring divider are pipelined, one result bit per stage each.
// The whole pipeline holds while a finished result waits and rsp_ready is low.
// Reset (synchronous, active high) empties the pipeline and loads the
// configuration registers with their reset values.
module drag_temperature_relaxation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_x,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_y,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_z,
   input  logic signed [drt_pkg::TEMP_W-1:0]  req_cell_temp,
   input  logic                               req_solid_flag,
   input  logic signed [drt_pkg::TEMP_W-1:0]  req_src_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [drt_pkg::TEMP_W-1:0]  rsp_src_out
);

   localparam int SQ_STEPS  = drt_pkg::ROOT_W;
   localparam int DIV_STEPS = drt_pkg::QUO_W;
   localparam int S_SUM     = 2;
   localparam int S_DIV0    = S_SUM + SQ_STEPS + 1;
   localparam int S_RATIO   = S_DIV0 + DIV_STEPS + 1;
   localparam int S_RATE    = S_RATIO + 1;
   localparam int S_PROD    = S_RATE + 1;
   localparam int S_FORCE   = S_PROD + 1;
   localparam int S_OUT     = S_FORCE + 1;

   logic adv;
   logic [S_OUT:0] v_ff;
   drt_pkg::pay_type pay_ff [0:S_FORCE];

   logic [drt_pkg::COEF_W-1:0] drag_ff, invh_ff;
   logic signed [drt_pkg::TEMP_W-1:0] soil_ff;

   logic [drt_pkg::VEL_W-1:0] mx_ff, my_ff, mz_ff;
   logic [2*drt_pkg::VEL_W-1:0] sqx_ff, sqy_ff, sqz_ff;

   logic [drt_pkg::SQ_W-1:0]   rad_ff  [0:SQ_STEPS];
   logic [drt_pkg::REM_W-1:0]  rem_ff  [0:SQ_STEPS];
   logic [drt_pkg::ROOT_W-1:0] root_ff [0:SQ_STEPS];
   logic [drt_pkg::SQ_W-1:0]   rad_in  [0:SQ_STEPS-1];
   logic [drt_pkg::REM_W-1:0]  rem_in  [0:SQ_STEPS-1];
   logic [drt_pkg::ROOT_W-1:0] root_in [0:SQ_STEPS-1];

   logic [drt_pkg::DEN_W-1:0] drem_ff [0:DIV_STEPS];
   logic [drt_pkg::DEN_W-1:0] den_ff  [0:DIV_STEPS];
   logic [drt_pkg::QUO_W-1:0] quo_ff  [0:DIV_STEPS];
   logic [drt_pkg::QUO_W-1:0] tail_ff [0:DIV_STEPS];
   logic                      clamp_ff[0:DIV_STEPS];
   logic [drt_pkg::DEN_W-1:0] drem_in [0:DIV_STEPS-1];
   logic [drt_pkg::QUO_W-1:0] quo_in  [0:DIV_STEPS-1];

   logic [drt_pkg::DEN_W-1:0] den0_in;

   logic [drt_pkg::QUO_W-1:0]  ratio_ff;
   logic [drt_pkg::RATE_W-1:0] rate_ff;
   logic [drt_pkg::DIFF_W-1:0] dmag_in;
   logic [43:0]                plo_ff;
   logic [44:0]                phi_ff;
   logic [60:0]                fsum_in;
   logic [drt_pkg::FMAG_W-1:0] fmag_ff;
   logic signed [drt_pkg::RES_W-1:0] res_in;
   logic signed [drt_pkg::TEMP_W-1:0] out_ff, out_in;

   assign adv       = !v_ff[S_OUT] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = v_ff[S_OUT];
   assign rsp_src_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         drag_ff <= drt_pkg::DRAG_RESET;
         invh_ff <= drt_pkg::INV_H_RESET;
         soil_ff <= drt_pkg::SOIL_RESET;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               drt_pkg::CSR_DRAG_COEFF:      drag_ff <= csr_data[drt_pkg::COEF_W-1:0];
               drt_pkg::CSR_INV_CELL_HEIGHT: invh_ff <= csr_data[drt_pkg::COEF_W-1:0];
               drt_pkg::CSR_SOIL_TEMP:       soil_ff <= csr_data;
               default: ;
            endcase
         end
         if (adv) begin
            v_ff <= {v_ff[S_OUT-1:0], req_valid};
         end
      end
   end

   // square root, two radicand bits per stage
   always_comb begin
      logic [drt_pkg::REM_W+1:0] rt, trial;
      for (int k = 0; k < SQ_STEPS; k++) begin
         rt    = {rem_ff[k], rad_ff[k][drt_pkg::SQ_W-1 -: 2]};
         trial = {2'b00, root_ff[k], 2'b01};
         rad_in[k] = {rad_ff[k][drt_pkg::SQ_W-3:0], 2'b00};
         if (rt >= trial) begin
            rt          = rt - trial;
            root_in[k]  = {root_ff[k][drt_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            root_in[k]  = {root_ff[k][drt_pkg::ROOT_W-2:0], 1'b0};
         end
         rem_in[k] = rt[drt_pkg::REM_W-1:0];
      end
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      logic [drt_pkg::DEN_W:0] rt;
      for (int k = 0; k < DIV_STEPS; k++) begin
         rt = {drem_ff[k], tail_ff[k][drt_pkg::QUO_W-1]};
         if (rt >= {1'b0, den_ff[k]}) begin
            rt        = rt - {1'b0, den_ff[k]};
            quo_in[k] = {quo_ff[k][drt_pkg::QUO_W-2:0], 1'b1};
         end else begin
            quo_in[k] = {quo_ff[k][drt_pkg::QUO_W-2:0], 1'b0};
         end
         drem_in[k] = rt[drt_pkg::DEN_W-1:0];
      end
   end

   function automatic logic signed [drt_pkg::RES_W-1:0] RES_W_SRC(
      input logic signed [drt_pkg::TEMP_W-1:0] s);
      RES_W_SRC = {{(drt_pkg::RES_W-drt_pkg::TEMP_W){s[drt_pkg::TEMP_W-1]}}, s};
   endfunction

   always_comb begin
      den0_in = {1'b0, root_ff[SQ_STEPS]} + 1'b1;
      dmag_in = pay_ff[S_RATE].diff[drt_pkg::DIFF_W-1] ?
                (~pay_ff[S_RATE].diff + 1'b1) : pay_ff[S_RATE].diff;
      fsum_in = {17'd0, plo_ff} + {phi_ff, 16'd0};
      res_in  = RES_W_SRC(pay_ff[S_FORCE].src) -
                (pay_ff[S_FORCE].diff[drt_pkg::DIFF_W-1] ?
                 -$signed({3'b000, fmag_ff}) : $signed({3'b000, fmag_ff}));
      if (!pay_ff[S_FORCE].solid) begin
         out_in = pay_ff[S_FORCE].src;
      end else if (res_in > 48'sd2147483647) begin
         out_in = 32'sh7FFF_FFFF;
      end else if (res_in < -48'sd2147483648) begin
         out_in = 32'sh8000_0000;
      end else begin
         out_in = res_in[drt_pkg::TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0].solid <= req_solid_flag;
         pay_ff[0].src   <= req_src_in;
         pay_ff[0].diff  <= {req_cell_temp[drt_pkg::TEMP_W-1], req_cell_temp} -
                            {soil_ff[drt_pkg::TEMP_W-1], soil_ff};
         for (int s = 0; s < S_FORCE; s++) begin
            pay_ff[s+1] <= pay_ff[s];
         end
         mx_ff <= drt_pkg::vel_mag(req_vel_x);
         my_ff <= drt_pkg::vel_mag(req_vel_y);
         mz_ff <= drt_pkg::vel_mag(req_vel_z);
         sqx_ff <= mx_ff * mx_ff;
         sqy_ff <= my_ff * my_ff;
         sqz_ff <= mz_ff * mz_ff;
         rad_ff[0]  <= sqx_ff + sqy_ff + sqz_ff;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         for (int k = 0; k < SQ_STEPS; k++) begin
            rad_ff[k+1]  <= rad_in[k];
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
         end
         den_ff[0]   <= den0_in;
         clamp_ff[0] <= {5'd0, drag_ff[drt_pkg::COEF_W-1:4]} >= den0_in;
         drem_ff[0]  <= {5'd0, drag_ff[drt_pkg::COEF_W-1:4]};
         tail_ff[0]  <= {drag_ff[3:0], 16'd0};
         quo_ff[0]   <= '0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            drem_ff[k+1]  <= drem_in[k];
            quo_ff[k+1]   <= quo_in[k];
            tail_ff[k+1]  <= {tail_ff[k][drt_pkg::QUO_W-2:0], 1'b0};
            den_ff[k+1]   <= den_ff[k];
            clamp_ff[k+1] <= clamp_ff[k];
         end
         ratio_ff <= (clamp_ff[DIV_STEPS] || quo_ff[DIV_STEPS] > drt_pkg::RATE_LIMIT) ?
                     drt_pkg::RATE_LIMIT : quo_ff[DIV_STEPS];
         rate_ff  <= 28'((44'(ratio_ff) * 44'(invh_ff)) >> 16);
         plo_ff   <= 44'(rate_ff) * 44'(dmag_in[15:0]);
         phi_ff   <= 45'(rate_ff) * 45'(dmag_in[drt_pkg::DIFF_W-1:16]);
         fmag_ff  <= fsum_in[60:16];
         out_ff   <= out_in;
      end
   end

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      adv && v_ff[S_FORCE] && !pay_ff[S_FORCE].solid |=> rsp_src_out == $past(pay_ff[S_FORCE].src))
      else $error("fluid cell source altered");

   a_ratio_limit: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_RATIO] |-> ratio_ff <= drt_pkg::RATE_LIMIT)
      else $error("drag ratio above limit");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_DIV0 + DIV_STEPS] && !clamp_ff[DIV_STEPS] |->
         drem_ff[DIV_STEPS] < den_ff[DIV_STEPS])
      else $error("divider remainder not below divisor");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== bench/drt_checker.sv =====
`timescale 1ns / 100ps

module drt_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_x,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_y,
   input  logic signed [drt_pkg::VEL_W-1:0]   req_vel_z,
   input  logic signed [drt_pkg::TEMP_W-1:0]  req_cell_temp,
   input  logic                               req_solid_flag,
   input  logic signed [drt_pkg::TEMP_W-1:0]  req_src_in,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [drt_pkg::TEMP_W-1:0]  rsp_src_out,
   output int                                 fail_count,
   output int                                 pending_count
);

   logic [23:0]        drag_reg;
   logic [23:0]        inv_h_reg;
   logic signed [31:0] soil_reg;
   logic [31:0]        src_expected[$];

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] relaxed_source(
         input logic signed [23:0] vx, input logic signed [23:0] vy,
         input logic signed [23:0] vz, input logic signed [31:0] tc,
         input logic solid, input logic signed [31:0] src);
      logic [63:0] ax, ay, az, spd, ratio, rate, dmag, fmag;
      logic signed [63:0] diff, res;
      ax = vx < 0 ? -64'(vx) : 64'(vx);
      ay = vy < 0 ? -64'(vy) : 64'(vy);
      az = vz < 0 ? -64'(vz) : 64'(vz);
      res = 64'(src);
      if (solid) begin
         spd = root_floor(ax * ax + ay * ay + az * az);
         ratio = (64'(drag_reg) << 16) / (spd + 64'd1);
         if (ratio > 64'(drt_pkg::RATE_LIMIT)) ratio = 64'(drt_pkg::RATE_LIMIT);
         rate = (ratio * 64'(inv_h_reg)) >> 16;
         diff = 64'(tc) - 64'(soil_reg);
         dmag = diff < 0 ? -diff : diff;
         fmag = (rate * dmag) >> 16;
         res = diff < 0 ? res + $signed(fmag) : res - $signed(fmag);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
      end
      return res[31:0];
   endfunction

   assign pending_count = src_expected.size();

   always @(posedge clock) begin
      if (reset) begin
         drag_reg <= drt_pkg::DRAG_RESET;
         inv_h_reg <= drt_pkg::INV_H_RESET;
         soil_reg <= drt_pkg::SOIL_RESET;
         fail_count <= 0;
         src_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               drt_pkg::CSR_DRAG_COEFF: drag_reg <= csr_data[23:0];
               drt_pkg::CSR_INV_CELL_HEIGHT: inv_h_reg <= csr_data[23:0];
               drt_pkg::CSR_SOIL_TEMP: soil_reg <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            src_expected.push_back(relaxed_source(req_vel_x, req_vel_y, req_vel_z,
                  req_cell_temp, req_solid_flag, req_src_in));
         if (rsp_valid && rsp_ready) begin
            if (src_expected.size() == 0) begin
               $display("%0t: unexpected transfer src_out=%h", $time, rsp_src_out);
               fail_count <= fail_count + 1;
            end else begin
               if (src_expected[0] !== rsp_src_out) begin
                  $display("%0t: src_out expected %h actual %h", $time,
                        src_expected[0], rsp_src_out);
                  fail_count <= fail_count + 1;
               end
               void'(src_expected.pop_front());
            end
         end
      end
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   logic req_valid = 0, req_ready;
   logic signed [23:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic signed [31:0] req_cell_temp = 0, req_src_in = 0;
   logic req_solid_flag = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_src_out;
   int fail_count, pending_count;
   int send_idle = 0, recv_idle = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   drag_temperature_relaxation DUT (.*);
   drt_checker u_checker (.*);

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic write_reg(input drt_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_cell(input logic [23:0] vx, input logic [23:0] vy,
         input logic [23:0] vz, input logic [31:0] tc, input logic solid,
         input logic [31:0] src);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_cell_temp <= tc;
      req_solid_flag <= solid;
      req_src_in <= src;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_vel();
      case ($urandom_range(3))
         0: return 24'($urandom_range(255) - 128);
         1: return 24'($urandom_range(2000000) - 1000000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom_range(40000000, 10000000);
         1: return {$urandom_range(1) ? 32'h7FFF0000 : 32'h80000000} | $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(input int count);
      repeat (count)
         send_cell(rand_vel(), rand_vel(), rand_vel(), rand_word(),
               $urandom_range(3) != 0, rand_word());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      // reset configuration
      send_cell(24'h7FFFFF, 24'h800000, 24'h000001, 32'h7FFFFFFF, 1'b1, 32'h12345678);
      drain();
      write_reg(drt_pkg::CSR_DRAG_COEFF, 32'hFF00FFFF);
      write_reg(drt_pkg::CSR_INV_CELL_HEIGHT, 32'h01FFFFFF);
      write_reg(drt_pkg::CSR_SOIL_TEMP, 32'h80000000);
      // zero speed, saturation to the minimum, fluid pass-through
      send_cell(24'd0, 24'd0, 24'd0, 32'h7FFFFFFF, 1'b1, 32'h80000000);
      send_cell(24'd0, 24'd0, 24'd0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF);
      send_cell(24'd0, 24'd0, 24'd0, 32'h7FFFFFFF, 1'b0, 32'h80000000);
      send_cell(24'h800000, 24'h800000, 24'h800000, 32'h80000000, 1'b1, 32'h7FFFFFFF);
      send_cell(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h0, 1'b1, 32'h0);
      drain();
      write_reg(drt_pkg::CSR_SOIL_TEMP, 32'h7FFFFFFF);
      send_cell(24'd0, 24'd0, 24'd0, 32'h80000000, 1'b1, 32'h7FFFFFFF);
      send_cell(24'h000100, 24'hFFFF00, 24'd0, 32'h80000000, 1'b1, 32'h0);
      send_cell(24'h010000, 24'd0, 24'd0, 32'h7FFFFFFF, 1'b1, 32'hFFFFFFFF);
      drain();
      write_reg(drt_pkg::CSR_DRAG_COEFF, 32'd0);
      write_reg(drt_pkg::CSR_INV_CELL_HEIGHT, 32'd0);
      send_cell(24'h123456, 24'h654321, 24'hABCDEF, 32'h80000000, 1'b1, 32'h55AA55AA);
      drain();
      write_reg(drt_pkg::CSR_DRAG_COEFF, 32'h00010000);
      write_reg(drt_pkg::CSR_INV_CELL_HEIGHT, 32'h00010000);
      write_reg(drt_pkg::CSR_SOIL_TEMP, 32'd19660800);
      send_idle = 12;
      recv_idle = 74;
      random_phase(300);
      drain();
      write_reg(drt_pkg::CSR_DRAG_COEFF, $urandom);
      write_reg(drt_pkg::CSR_INV_CELL_HEIGHT, $urandom);
      write_reg(drt_pkg::CSR_SOIL_TEMP, $urandom);
      send_idle = 74;
      recv_idle = 12;
      random_phase(300);
      drain();
      write_reg(drt_pkg::CSR_DRAG_COEFF, $urandom_range(65535));
      write_reg(drt_pkg::CSR_INV_CELL_HEIGHT, 32'hFFFFFF);
      write_reg(drt_pkg::CSR_SOIL_TEMP, rand_word());
      send_idle = 0;
      recv_idle = 0;
      random_phase(300);
      drain();
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
